/* rtl/mtrp_pkg.sv */
// Package: shared types and constants for the Modbus TCP read-response parser.
`timescale 1ns / 1ps

package mtrp_pkg;

  // Input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_REQ_BYTE = 2'd0;
  localparam logic [1:0] KIND_WORD     = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_EXCEPTION = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_UNIT_ID = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam int CFG_DW = 16;

  // Protocol constants
  localparam logic [15:0] TRANS_ID_RESET = 16'hA100;
  localparam logic [7:0]  UNIT_ID_RESET  = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd2500;
  localparam logic [7:0]  MB_FUNC_READ   = 8'h03;
  localparam logic [7:0]  MB_REQ_LEN     = 8'd6;
  localparam logic [7:0]  MB_PROTO_BYTE  = 8'h00;
  localparam int          BODY_MAX       = 256;
  localparam logic [2:0]  HDR_LAST       = 3'd7;

  // Request frame byte positions
  localparam logic [3:0] REQ_ID_HI   = 4'd0;
  localparam logic [3:0] REQ_ID_LO   = 4'd1;
  localparam logic [3:0] REQ_LEN_LO  = 4'd5;
  localparam logic [3:0] REQ_UNIT    = 4'd6;
  localparam logic [3:0] REQ_FUNC    = 4'd7;
  localparam logic [3:0] REQ_ADDR_HI = 4'd8;
  localparam logic [3:0] REQ_ADDR_LO = 4'd9;
  localparam logic [3:0] REQ_CNT_LO  = 4'd11;
  localparam logic [3:0] REQ_LAST    = 4'd11;

  // Command queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_REQ,
    OP_WORD,
    OP_STATUS,
    OP_WORD_STATUS
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] trans_id;
    logic [7:0]  unit;
    logic [15:0] addr;
    logic [6:0]  cnt;
    logic [6:0]  idx;
    logic [15:0] value;
    logic [2:0]  status;
  } cmd_t;

endpackage

/* rtl/mtrp_front.sv */
// Front end: accepts items, tracks the transaction and frame parse, issues commands.
`timescale 1ns / 1ps

module mtrp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mtrp_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                          accept,
  input  logic [1:0]                    action,
  input  logic [15:0]                   req_addr,
  input  logic [6:0]                    req_count,
  input  logic [7:0]                    rx_byte,
  output logic                          push,
  output mtrp_pkg::cmd_t                push_cmd
);
  import mtrp_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_BODY} phase_t;

  phase_t      phase, phase_next;
  logic [15:0] trans_id, trans_id_next;
  logic [2:0]  header_pos, header_pos_next;
  logic [15:0] rx_trans_id, rx_trans_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  body_pos, body_pos_next;
  logic [7:0]  body_last, body_last_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [6:0]  want_count, want_count_next;
  logic [2:0]  pending_error, pending_error_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic        id_match, id_match_next;
  logic [7:0]  unit_id;
  logic [15:0] timeout_ticks;

  logic        hdr_match;
  logic [2:0]  pend;
  logic        word;
  logic [6:0]  word_idx;
  logic [15:0] timer_inc;

  assign hdr_match = (rx_trans_id == trans_id);
  assign word_idx  = body_pos[7:1] - 7'd1;
  assign timer_inc = (wait_timer != 16'hFFFF) ? wait_timer + 16'd1 : wait_timer;

  always_comb begin
    phase_next         = phase;
    trans_id_next      = trans_id;
    header_pos_next    = header_pos;
    rx_trans_id_next   = rx_trans_id;
    frame_length_next  = frame_length;
    body_pos_next      = body_pos;
    body_last_next     = body_last;
    high_byte_next     = high_byte;
    want_count_next    = want_count;
    pending_error_next = pending_error;
    wait_timer_next    = wait_timer;
    id_match_next      = id_match;
    pend               = pending_error;
    word               = 1'b0;
    push               = 1'b0;
    push_cmd           = '0;
    push_cmd.op        = OP_STATUS;
    push_cmd.trans_id  = trans_id + 16'd1;
    push_cmd.unit      = unit_id;
    push_cmd.addr      = req_addr;
    push_cmd.cnt       = req_count;
    push_cmd.idx       = word_idx;
    push_cmd.value     = {high_byte, rx_byte};
    if (accept) begin
      case (action)
        ACT_START: begin
          trans_id_next      = trans_id + 16'd1;
          push               = 1'b1;
          push_cmd.op        = OP_REQ;
          phase_next         = PH_HEAD;
          header_pos_next    = '0;
          body_pos_next      = '0;
          high_byte_next     = '0;
          want_count_next    = req_count;
          pending_error_next = ST_OK;
          wait_timer_next    = '0;
        end
        ACT_BYTE: begin
          case (phase)
            PH_HEAD: begin
              case (header_pos)
                3'd0: rx_trans_id_next[15:8] = rx_byte;
                3'd1: rx_trans_id_next[7:0] = rx_byte;
                3'd4: frame_length_next[15:8] = rx_byte;
                3'd5: frame_length_next[7:0] = rx_byte;
                default: ;
              endcase
              if (header_pos == HDR_LAST) begin
                header_pos_next = '0;
                if (frame_length < 16'd2 || frame_length > 16'(BODY_MAX + 2)) begin
                  push            = 1'b1;
                  push_cmd.status = ST_BAD_LEN;
                  phase_next      = PH_IDLE;
                end else begin
                  pend               = (hdr_match && rx_byte[7]) ? ST_EXCEPTION : ST_OK;
                  pending_error_next = pend;
                  id_match_next      = hdr_match;
                  if (frame_length == 16'd2) begin
                    if (hdr_match) begin
                      push            = 1'b1;
                      push_cmd.status = (pend != ST_OK) ? pend : ST_SHORT;
                      phase_next      = PH_IDLE;
                    end
                  end else begin
                    phase_next     = PH_BODY;
                    body_pos_next  = '0;
                    body_last_next = 8'(frame_length - 16'd3);
                  end
                end
              end else begin
                header_pos_next = header_pos + 3'd1;
              end
            end
            PH_BODY: begin
              if (id_match) begin
                if (body_pos == 8'd0) begin
                  if (pend == ST_OK &&
                      (rx_byte < {want_count, 1'b0} || body_last < rx_byte))
                    pend = ST_SHORT;
                end else if (body_pos[0]) begin
                  high_byte_next = rx_byte;
                end else if (pend == ST_OK && word_idx < want_count) begin
                  word = 1'b1;
                end
              end
              pending_error_next = pend;
              if (body_pos == body_last) begin
                if (id_match) begin
                  push            = 1'b1;
                  push_cmd.op     = word ? OP_WORD_STATUS : OP_STATUS;
                  push_cmd.status = pend;
                  phase_next      = PH_IDLE;
                end else begin
                  phase_next      = PH_HEAD;
                  header_pos_next = '0;
                end
              end else begin
                body_pos_next = body_pos + 8'd1;
                if (word) begin
                  push        = 1'b1;
                  push_cmd.op = OP_WORD;
                end
              end
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          if (phase != PH_IDLE) begin
            wait_timer_next = timer_inc;
            if (timer_inc >= timeout_ticks) begin
              push            = 1'b1;
              push_cmd.status = ST_TIMEOUT;
              phase_next      = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      trans_id      <= TRANS_ID_RESET;
      header_pos    <= '0;
      rx_trans_id   <= '0;
      frame_length  <= '0;
      body_pos      <= '0;
      body_last     <= '0;
      high_byte     <= '0;
      want_count    <= '0;
      pending_error <= ST_OK;
      wait_timer    <= '0;
      id_match      <= 1'b0;
      unit_id       <= UNIT_ID_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      phase         <= phase_next;
      trans_id      <= trans_id_next;
      header_pos    <= header_pos_next;
      rx_trans_id   <= rx_trans_id_next;
      frame_length  <= frame_length_next;
      body_pos      <= body_pos_next;
      body_last     <= body_last_next;
      high_byte     <= high_byte_next;
      want_count    <= want_count_next;
      pending_error <= pending_error_next;
      wait_timer    <= wait_timer_next;
      id_match      <= id_match_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNIT_ID: unit_id <= cfg_data[7:0];
          CFG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/mtrp_queue.sv */
// Command queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module mtrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtrp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output mtrp_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import mtrp_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10: count <= count + (QAW+1)'(1);
        2'b01: count <= count - (QAW+1)'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue pushed while full");
`endif

endmodule

/* rtl/mtrp_back.sv */
// Result sequencer: expands queued commands into result items behind an output register.
`timescale 1ns / 1ps

module mtrp_back (
  input  logic           clk,
  input  logic           rst,
  input  mtrp_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     kind,
  output logic [7:0]     tx_byte,
  output logic [6:0]     reg_index,
  output logic [15:0]    reg_value,
  output logic [2:0]     status,
  output logic           last
);
  import mtrp_pkg::*;

  logic [3:0]  step;
  logic        load;
  logic        done;
  logic [1:0]  res_kind;
  logic [7:0]  res_tx;
  logic [6:0]  res_idx;
  logic [15:0] res_value;
  logic [2:0]  res_status;
  logic        res_last;

  assign load = !empty && (!out_valid || !out_stall);
  assign pop  = load && done;

  always_comb begin
    res_kind   = KIND_STATUS;
    res_tx     = '0;
    res_idx    = '0;
    res_value  = '0;
    res_status = '0;
    res_last   = 1'b1;
    done       = 1'b1;
    case (head.op)
      OP_REQ: begin
        res_kind = KIND_REQ_BYTE;
        case (step)
          REQ_ID_HI:   res_tx = head.trans_id[15:8];
          REQ_ID_LO:   res_tx = head.trans_id[7:0];
          REQ_LEN_LO:  res_tx = MB_REQ_LEN;
          REQ_UNIT:    res_tx = head.unit;
          REQ_FUNC:    res_tx = MB_FUNC_READ;
          REQ_ADDR_HI: res_tx = head.addr[15:8];
          REQ_ADDR_LO: res_tx = head.addr[7:0];
          REQ_CNT_LO:  res_tx = {1'b0, head.cnt};
          default:     res_tx = MB_PROTO_BYTE;
        endcase
        res_last = (step == REQ_LAST);
        done     = (step == REQ_LAST);
      end
      OP_WORD: begin
        res_kind  = KIND_WORD;
        res_idx   = head.idx;
        res_value = head.value;
      end
      OP_STATUS: begin
        res_status = head.status;
      end
      OP_WORD_STATUS: begin
        if (step == 4'd0) begin
          res_kind  = KIND_WORD;
          res_idx   = head.idx;
          res_value = head.value;
          res_last  = 1'b0;
          done      = 1'b0;
        end else begin
          res_status = head.status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= done ? 4'd0 : step + 4'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= res_kind;
      tx_byte   <= res_tx;
      reg_index <= res_idx;
      reg_value <= res_value;
      status    <= res_status;
      last      <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> last)
    else $error("status item without last");
  a_step_holds_head: assert property (@(posedge clk) disable iff (rst)
    step != 4'd0 |-> !empty)
    else $error("command left the queue mid-expansion");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= REQ_LAST)
    else $error("step counter out of range");
`endif

endmodule

/* rtl/modbus_tcp_read_response_parser_unit.sv */
// Top level: Modbus TCP read-holding-registers client, request builder and response parser.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_stall, action, req_addr, req_count, | in
//          | rx_byte                                          |
//  out     | out_valid, out_stall, kind, tx_byte, reg_index,  | out
//          | reg_value, status, last                          |
//  cfg     | cfg_we, cfg_index, cfg_data                      | in
//
// One input item per cycle while in_stall is low; the parse state is registered.
// Results leave one per cycle while out_stall is low: 12 per start item, up to 2 per byte.
// The 4-entry command queue absorbs this; in_stall rises only when it is full.
// Reset is synchronous; the block is ready the cycle after rst falls.
`timescale 1ns / 1ps

module modbus_tcp_read_response_parser_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mtrp_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [15:0]                 req_addr,
  input  logic [6:0]                  req_count,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  tx_byte,
  output logic [6:0]                  reg_index,
  output logic [15:0]                 reg_value,
  output logic [2:0]                  status,
  output logic                        last
);
  import mtrp_pkg::*;

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mtrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .action    (action),
    .req_addr  (req_addr),
    .req_count (req_count),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mtrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  mtrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .status    (status),
    .last      (last)
  );

endmodule

/* tb/sv/tb_modbus_tcp_read_response_parser_unit.sv */
// Testbench: request frames, response parsing and timeouts of the Modbus TCP read unit.
`timescale 1ns / 1ps

module tb_modbus_tcp_read_response_parser_unit;
  import mtrp_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] EXC_BIT    = 8'h80;

  typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_BODY} rx_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  status;
    logic        last;
  } mb_result_t;

  class modbus_read_scoreboard;
    mb_result_t  expected_results[$];
    int          errors;
    logic [7:0]  unit_id;
    logic [15:0] timeout_ticks;
    logic [15:0] trans_id;
    rx_phase_t   phase;
    logic [2:0]  header_pos;
    logic [15:0] rx_id;
    logic [15:0] frame_len;
    logic [7:0]  func;
    logic [8:0]  body_pos;
    logic [7:0]  high_byte;
    logic [6:0]  want;
    logic [2:0]  pend_err;
    logic [15:0] wait_timer;

    function new();
      errors = 0;
      unit_id = UNIT_ID_RESET;
      timeout_ticks = TIMEOUT_RESET;
      trans_id = TRANS_ID_RESET;
      phase = RX_IDLE;
      header_pos = '0;
      rx_id = '0;
      frame_len = '0;
      func = '0;
      body_pos = '0;
      high_byte = '0;
      want = '0;
      pend_err = ST_OK;
      wait_timer = '0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == CFG_UNIT_ID) unit_id = data[7:0];
      else timeout_ticks = data;
    endfunction

    function void expect_result(logic [1:0] k, logic [7:0] tx, logic [6:0] idx,
                                logic [15:0] val, logic [2:0] st, logic lst);
      expected_results.push_back('{k, tx, idx, val, st, lst});
    endfunction

    function void end_transaction(logic [2:0] st);
      expect_result(KIND_STATUS, '0, '0, '0, st, 1'b1);
      phase = RX_IDLE;
    endfunction

    // Predicts the results of one accepted item and advances the parse state.
    function void note_item(logic [1:0] act, logic [15:0] addr, logic [6:0] cnt,
                            logic [7:0] b);
      logic [7:0] frame [12];
      int blen;
      bit match;
      bit ends;
      int widx;
      case (act)
        ACT_START: begin
          trans_id++;
          frame = '{trans_id[15:8], trans_id[7:0], MB_PROTO_BYTE, MB_PROTO_BYTE,
                    8'h00, MB_REQ_LEN, unit_id, MB_FUNC_READ, addr[15:8], addr[7:0],
                    8'h00, {1'b0, cnt}};
          for (int i = 0; i < 12; i++)
            expect_result(KIND_REQ_BYTE, frame[i], '0, '0, ST_OK, i == REQ_LAST);
          phase = RX_HEADER;
          header_pos = '0;
          body_pos = '0;
          high_byte = '0;
          want = cnt;
          pend_err = ST_OK;
          wait_timer = '0;
        end
        ACT_BYTE: begin
          if (phase == RX_HEADER) begin
            case (header_pos)
              3'd0: rx_id[15:8] = b;
              3'd1: rx_id[7:0] = b;
              3'd4: frame_len[15:8] = b;
              3'd5: frame_len[7:0] = b;
              HDR_LAST: func = b;
              default: ;
            endcase
            if (header_pos != HDR_LAST) begin
              header_pos++;
              return;
            end
            header_pos = '0;
            match = (rx_id == trans_id);
            blen = int'(frame_len) - 2;
            if (blen < 0 || blen > BODY_MAX) begin
              end_transaction(ST_BAD_LEN);
              return;
            end
            pend_err = (match && (func & EXC_BIT) != 0) ? ST_EXCEPTION : ST_OK;
            if (blen == 0) begin
              if (match) end_transaction(pend_err != ST_OK ? pend_err : ST_SHORT);
              return;
            end
            phase = RX_BODY;
            body_pos = '0;
          end else if (phase == RX_BODY) begin
            blen = int'(frame_len) - 2;
            match = (rx_id == trans_id);
            ends = (int'(body_pos) + 1 >= blen);
            if (match) begin
              if (body_pos == 0) begin
                if (pend_err == ST_OK && (int'(b) < 2 * int'(want) || blen < 1 + int'(b)))
                  pend_err = ST_SHORT;
              end else if (body_pos[0]) begin
                high_byte = b;
              end else if (pend_err == ST_OK) begin
                widx = (int'(body_pos) - 2) / 2;
                if (widx < int'(want))
                  expect_result(KIND_WORD, '0, widx[6:0], {high_byte, b}, ST_OK, !ends);
              end
            end
            if (ends) begin
              if (match) begin
                end_transaction(pend_err);
              end else begin
                phase = RX_HEADER;
                header_pos = '0;
              end
              return;
            end
            body_pos++;
          end
        end
        ACT_TICK: begin
          if (phase != RX_IDLE) begin
            if (wait_timer != '1) wait_timer++;
            if (wait_timer >= timeout_ticks) end_transaction(ST_TIMEOUT);
          end
        end
        default: ;
      endcase
    endfunction

    task report_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want_val);
      if (got !== want_val)
        report_error($sformatf("%s: got %0h, expected %0h", name, got, want_val));
    endtask

    task check_result(mb_result_t got);
      mb_result_t exp;
      if (expected_results.size() == 0) begin
        report_error("result with no expected item pending");
        return;
      end
      exp = expected_results.pop_front();
      compare_field("kind", 16'(got.kind), 16'(exp.kind));
      compare_field("tx_byte", 16'(got.tx_byte), 16'(exp.tx_byte));
      compare_field("reg_index", 16'(got.reg_index), 16'(exp.reg_index));
      compare_field("reg_value", got.reg_value, exp.reg_value);
      compare_field("status", 16'(got.status), 16'(exp.status));
      compare_field("last", 16'(got.last), 16'(exp.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [15:0] req_addr;
  logic [6:0]  req_count;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [6:0]  reg_index;
  logic [15:0] reg_value;
  logic [2:0]  status;
  logic        last;

  modbus_read_scoreboard predictor;
  int send_idle_pct;
  int recv_idle_pct;
  int tick_pct;
  int items_sent;
  bit hold_req;

  localparam logic [7:0]  UNIT_SET[6]    = '{8'hFF, 8'h5A, 8'h01, 8'h00, 8'hC3, 8'hA5};
  localparam logic [15:0] TIMEOUT_SET[6] = '{16'hFFFF, 16'd40, 16'd1, 16'd0, 16'd300,
                                             16'd2500};

  modbus_tcp_read_response_parser_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .req_addr(req_addr),
    .req_count(req_count), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
    .reg_index(reg_index), .reg_value(reg_value), .status(status), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall, or a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      predictor.check_result('{kind, tx_byte, reg_index, reg_value, status, last});
  end

  task automatic send_item(logic [1:0] act, logic [15:0] addr, logic [6:0] cnt,
                           logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    req_addr <= addr;
    req_count <= cnt;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_item(act, addr, cnt, b);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < tick_pct)
      send_item(ACT_TICK, 16'($urandom), 7'($urandom), 8'($urandom));
    send_item(ACT_BYTE, 16'($urandom), 7'($urandom), b);
  endtask

  task automatic send_header(logic [15:0] id, logic [15:0] len, logic [7:0] fn);
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_byte($urandom_range(7) == 0 ? 8'($urandom) : MB_PROTO_BYTE);
    send_byte(MB_PROTO_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(8'($urandom));
    send_byte(fn);
  endtask

  task automatic send_frame(logic [15:0] id, logic [7:0] fn, logic [7:0] bc, int blen);
    send_header(id, 16'(blen + 2), fn);
    for (int i = 0; i < blen; i++) send_byte(i == 0 ? bc : 8'($urandom));
  endtask

  task automatic write_config(logic [7:0] unit, logic [15:0] ticks);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNIT_ID;
    cfg_data <= {8'h00, unit};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.write_reg(CFG_UNIT_ID, {8'h00, unit});
    predictor.write_reg(CFG_TIMEOUT, ticks);
  endtask

  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (predictor.expected_results.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  // One request followed by a good, broken or foreign response frame, or by ticks alone; random items may come first.
  task automatic run_transaction();
    int sel;
    int cnt;
    int bc;
    logic [15:0] id;
    logic [7:0] fn;
    if ($urandom_range(19) == 0)
      repeat ($urandom_range(4, 1))
        send_item(2'($urandom_range(3)), 16'($urandom), 7'($urandom), 8'($urandom));
    sel = $urandom_range(99);
    cnt = sel < 80 ? $urandom_range(6) : sel < 98 ? $urandom_range(30, 7) :
          $urandom_range(127, 31);
    send_item(ACT_START, 16'($urandom), 7'(cnt), 8'($urandom));
    id = predictor.trans_id;
    case ($urandom_range(9))
      5: send_frame(id, 8'($urandom) | EXC_BIT, 8'($urandom), $urandom_range(3));
      6: begin
        bc = $urandom_range(2 * cnt + 4);
        if (bc > 255) bc = 255;
        send_frame(id, MB_FUNC_READ, 8'(bc), $urandom_range(bc));
      end
      7: begin
        send_frame(id ^ (16'h1 << $urandom_range(15)), 8'($urandom), 8'($urandom),
                   $urandom_range(5));
        send_frame(id, MB_FUNC_READ, 8'(2 * cnt), 1 + 2 * cnt);
      end
      8: begin
        case ($urandom_range(2))
          0: bc = $urandom_range(1);
          1: bc = $urandom_range(65535, 259);
          default: bc = BODY_MAX + 3;
        endcase
        send_header($urandom_range(1) ? id : 16'($urandom), 16'(bc), MB_FUNC_READ);
      end
      9: repeat ($urandom_range(50, 1))
        send_item(ACT_TICK, 16'($urandom), 7'($urandom), 8'($urandom));
      default: begin
        fn = $urandom_range(9) == 0 ? (8'($urandom) & ~EXC_BIT) : MB_FUNC_READ;
        send_frame(id, fn, 8'(2 * cnt),
                   1 + 2 * cnt + ($urandom_range(4) == 0 ? $urandom_range(3) : 0));
      end
    endcase
  endtask

  initial begin
    int target;
    bit paused;
    predictor = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_UNIT_ID;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_TICK;
    req_addr = '0;
    req_count = '0;
    rx_byte = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    tick_pct = 0;
    items_sent = 0;
    hold_req = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items
    write_config(8'h3C, 16'd3);
    send_item(ACT_BYTE, 16'h0000, 7'd0, 8'h55);
    send_item(ACT_TICK, 16'h0000, 7'd0, 8'h00);
    send_item(ACT_UNUSED, 16'hFFFF, 7'h7F, 8'hFF);
    send_item(ACT_START, 16'hFFFF, 7'd127, 8'h00);
    send_item(ACT_START, 16'h1234, 7'd1, 8'h00);
    send_frame(predictor.trans_id, MB_FUNC_READ, 8'd2, 3);
    send_item(ACT_START, 16'h0000, 7'd0, 8'h00);
    repeat (3) send_item(ACT_TICK, 16'h0000, 7'd0, 8'h00);
    wait_drained();

    tick_pct = 3;
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = p < 2 ? 19 : p < 4 ? 57 : 0;
      recv_idle_pct = p < 2 ? 57 : p < 4 ? 19 : 0;
      write_config(UNIT_SET[p], TIMEOUT_SET[p]);
      if (p == 1) begin
        // receiver holds off while requests keep coming, so the input stalls
        hold_req = 1'b1;
        send_idle_pct = 0;
        repeat (6) send_item(ACT_START, 16'($urandom), 7'($urandom), 8'($urandom));
        send_idle_pct = 19;
      end
      target = items_sent + 70;
      while (items_sent < target) begin
        run_transaction();
        if (p == 3 && !paused && items_sent > target - 45) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      wait_drained();
    end

    if (predictor.expected_results.size() != 0)
      predictor.report_error("expected results left over at end of run");
    if (predictor.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
